>>> design/sfd_pkg.sv
// Shared types and constants for the skeletal frame decode unit.
// Used by the controller, the datapath and the top level; no dependencies.
package sfd_pkg;

  // Pose store depth: one entry per bone index
  localparam int MAX_BONES = 64;
  localparam int BONE_W    = $clog2(MAX_BONES);

  // Iteration counts of the shared sqrt and divide units
  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 31;

  // Datapath operation codes
  localparam logic [4:0] OP_NONE     = 5'd0;
  localparam logic [4:0] OP_LOAD     = 5'd1;
  localparam logic [4:0] OP_READ     = 5'd2;
  localparam logic [4:0] OP_WSQ      = 5'd3;
  localparam logic [4:0] OP_SQW_GO   = 5'd4;
  localparam logic [4:0] OP_SQW_WAIT = 5'd5;
  localparam logic [4:0] OP_H        = 5'd6;
  localparam logic [4:0] OP_C        = 5'd7;
  localparam logic [4:0] OP_Q        = 5'd8;
  localparam logic [4:0] OP_NORM     = 5'd9;
  localparam logic [4:0] OP_SUM      = 5'd10;
  localparam logic [4:0] OP_SQN_GO   = 5'd11;
  localparam logic [4:0] OP_SQN_WAIT = 5'd12;
  localparam logic [4:0] OP_DIV_GO   = 5'd13;
  localparam logic [4:0] OP_DIV_WAIT = 5'd14;
  localparam logic [4:0] OP_IDENT    = 5'd15;
  localparam logic [4:0] OP_FIN      = 5'd16;

  // Last step of each multiply-accumulate sequence and of the divide sequence
  localparam logic [3:0] LAST_WSQ = 4'd2;
  localparam logic [3:0] LAST_H   = 4'd5;
  localparam logic [3:0] LAST_C   = 4'd8;
  localparam logic [3:0] LAST_Q   = 4'd15;
  localparam logic [3:0] LAST_SUM = 4'd3;
  localparam logic [3:0] LAST_DIV = 4'd3;

  typedef struct packed {
    logic [4:0] op;
    logic [3:0] step;
  } sfd_cmd_t;

  typedef struct packed {
    logic is_root;
    logic sqrt_done;
    logic div_done;
    logic norm_big;
    logic norm_zero;
    logic out_free;
  } sfd_stat_t;

  typedef struct packed {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    logic signed [31:0] qw;
    logic signed [31:0] qx;
    logic signed [31:0] qy;
    logic signed [31:0] qz;
  } sfd_pose_t;

  typedef struct packed {
    logic [BONE_W-1:0]  bone_index;
    logic signed [6:0]  parent_index;
    logic [5:0]         channel_mask;
    logic signed [31:0] base_tx;
    logic signed [31:0] base_ty;
    logic signed [31:0] base_tz;
    logic signed [31:0] base_qx;
    logic signed [31:0] base_qy;
    logic signed [31:0] base_qz;
    logic [63:0]        frame_vals01;
    logic [63:0]        frame_vals23;
    logic [63:0]        frame_vals45;
  } sfd_in_t;

endpackage

>>> design/skeletal_frame_decode_unit.sv
// Top level of the skeletal frame decode unit: stream ports, controller, datapath.
// Depends on sfd_pkg, sfd_ctrl and sfd_dpath.
//
//  channel  | dir | handshake                      | payload
//  ---------+-----+--------------------------------+------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready  | one bone: base pose, mask, values
//  m_axis   | out | m_axis_tvalid / m_axis_tready  | bone index and world pose
//
// One bone at a time. A root bone needs only the sum of squares for w and its square root;
// a child bone also runs the rest of the shared multiply-accumulate (38 passes in
// all), a second bit-serial square root, the normalizing shift and four divides,
// which a zero norm replaces with the identity rotation.
// Reset is synchronous; the pose store is not cleared.
// A result waiting in the output register holds the next item at its last cycle.
module skeletal_frame_decode_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // bone_index, parent_index, channel_mask, base_tx, base_ty, base_tz,
  // base_qx, base_qy, base_qz, frame_vals01, frame_vals23, frame_vals45, pad
  input  logic [407:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_bone, out_tx, out_ty, out_tz, out_qw, out_qx, out_qy, out_qz, pad
  output logic [231:0] m_axis_tdata
);

  sfd_pkg::sfd_cmd_t  cmd;
  sfd_pkg::sfd_stat_t stat;
  sfd_pkg::sfd_in_t   in_item;
  sfd_pkg::sfd_pose_t out_pose;
  logic [sfd_pkg::BONE_W-1:0] out_bone;

  // Input unpack
  assign in_item.bone_index   = s_axis_tdata[5:0];
  assign in_item.parent_index = s_axis_tdata[12:6];
  assign in_item.channel_mask = s_axis_tdata[18:13];
  assign in_item.base_tx      = s_axis_tdata[50:19];
  assign in_item.base_ty      = s_axis_tdata[82:51];
  assign in_item.base_tz      = s_axis_tdata[114:83];
  assign in_item.base_qx      = s_axis_tdata[146:115];
  assign in_item.base_qy      = s_axis_tdata[178:147];
  assign in_item.base_qz      = s_axis_tdata[210:179];
  assign in_item.frame_vals01 = s_axis_tdata[274:211];
  assign in_item.frame_vals23 = s_axis_tdata[338:275];
  assign in_item.frame_vals45 = s_axis_tdata[402:339];

  sfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sfd_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_bone  (out_bone),
    .out_pose  (out_pose)
  );

  // Output pack
  assign m_axis_tdata = {2'b00, out_pose.qz, out_pose.qy, out_pose.qx, out_pose.qw,
                         out_pose.tz, out_pose.ty, out_pose.tx, out_bone};

`ifndef SYNTHESIS
  // One item in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  // A result appears only after the finishing command
  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(cmd.op == sfd_pkg::OP_FIN))
    else $error("output valid without a finished item");

  // The sqrt and divide units never finish together
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(stat.sqrt_done && stat.div_done))
    else $error("sqrt and divide finished in the same cycle");
`endif

endmodule

>>> design/sfd_sqrt.sv
// Bit-serial floor integer square root of a 64-bit value, one root bit per cycle.
// Depends on sfd_pkg for the iteration count.
module sfd_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] rad;
  logic [34:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [34:0] rem_sh;
  logic [34:0] trial;

  // Bring down two radicand bits and try the next root bit
  assign rem_sh = {rem[32:0], rad[63:62]};
  assign trial  = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(sfd_pkg::SQ_STEPS);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Root and remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[30:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[30:0], 1'b0};
      end
    end
  end

endmodule

>>> design/sfd_div.sv
// Restoring divider for (a * 2^30) / n, truncated toward zero, one quotient bit per cycle.
// Requires |a| <= n; depends on sfd_pkg for the iteration count.
module sfd_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        mag,
  input  logic               neg,
  input  logic [31:0]        den,
  output logic               done,
  output logic signed [31:0] quo
);

  logic [32:0] rem;
  logic [30:0] sh;
  logic [30:0] q;
  logic [31:0] dvs;
  logic        sgn;
  logic [4:0]  cnt;
  logic        busy;
  logic [32:0] r2;

  assign r2  = {rem[31:0], sh[30]};
  assign quo = sgn ? -$signed({1'b0, q}) : $signed({1'b0, q});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(sfd_pkg::DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Upper dividend bits start in the remainder: the quotient stays below 2^31
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {2'b00, mag[31:1]};
      sh  <= {mag[0], 30'd0};
      q   <= '0;
      dvs <= den;
      sgn <= neg;
    end else if (busy) begin
      sh <= {sh[29:0], 1'b0};
      if (r2 >= {1'b0, dvs}) begin
        rem <= r2 - {1'b0, dvs};
        q   <= {q[29:0], 1'b1};
      end else begin
        rem <= r2;
        q   <= {q[29:0], 1'b0};
      end
    end
  end

endmodule

>>> design/sfd_dpath.sv
// Datapath: input decode, shared multiply-accumulate, pose store, sqrt and divide units.
// Depends on sfd_pkg, sfd_sqrt and sfd_div.
module sfd_dpath (
  input  logic                clk,
  input  logic                rst,
  input  sfd_pkg::sfd_cmd_t   cmd,
  output sfd_pkg::sfd_stat_t  stat,
  input  sfd_pkg::sfd_in_t    in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [sfd_pkg::BONE_W-1:0] out_bone,
  output sfd_pkg::sfd_pose_t  out_pose
);

  function automatic logic signed [31:0] clamp_q(input logic signed [31:0] x);
    logic signed [31:0] r;
    r = x;
    if (x > 32'sd1073741824) r = 32'sd1073741824;
    else if (x < -32'sd1073741824) r = -32'sd1073741824;
    return r;
  endfunction

  // A negative value sitting at -2^31 is big only when no ones were shifted out
  function automatic logic is_big(input logic [63:0] x, input logic sticky);
    return (!x[63] && (|x[62:31])) ||
           (x[63] && (!(&x[62:31]) || (!(|x[30:0]) && !sticky)));
  endfunction

  sfd_pkg::sfd_pose_t pose_mem [sfd_pkg::MAX_BONES];
  sfd_pkg::sfd_pose_t rd;
  sfd_pkg::sfd_pose_t res;

  logic [sfd_pkg::BONE_W-1:0] bone;
  logic signed [6:0]  parent;
  logic signed [31:0] tl [3];
  logic signed [31:0] ql [3];
  logic signed [31:0] w;
  logic signed [32:0] h  [3];
  logic [63:0]        s  [4];
  logic [3:0]         lost;
  logic signed [31:0] wt [3];
  logic signed [31:0] wq [4];
  logic [31:0]        norm;
  logic               wzero;

  logic signed [31:0] vals [6];
  logic signed [31:0] t_in [3];
  logic signed [31:0] q_in [3];
  logic [2:0]         kcnt;

  logic signed [32:0] pv [4];
  logic signed [32:0] qv [4];
  logic signed [32:0] tv [3];
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod, acc, acc_next;
  logic               mac_en, msub, mclr;

  logic [1:0]         ci;
  logic signed [39:0] tsum;
  logic signed [31:0] tsat;

  logic               sq_start, sq_done, dv_start, dv_done;
  logic [63:0]        sq_rad;
  logic [31:0]        sq_root;
  logic [31:0]        dv_mag;
  logic signed [31:0] dv_a, dv_quo;
  logic               any_big;

  // Channel mask decode: the k-th set bit takes packed value k
  always_comb begin
    vals[0] = in_item.frame_vals01[31:0];
    vals[1] = in_item.frame_vals01[63:32];
    vals[2] = in_item.frame_vals23[31:0];
    vals[3] = in_item.frame_vals23[63:32];
    vals[4] = in_item.frame_vals45[31:0];
    vals[5] = in_item.frame_vals45[63:32];
    t_in[0] = in_item.base_tx;
    t_in[1] = in_item.base_ty;
    t_in[2] = in_item.base_tz;
    q_in[0] = in_item.base_qx;
    q_in[1] = in_item.base_qy;
    q_in[2] = in_item.base_qz;
    kcnt = '0;
    for (int b = 0; b < 3; b++) begin
      if (in_item.channel_mask[b]) begin
        t_in[b] = vals[kcnt];
        kcnt = kcnt + 3'd1;
      end
    end
    for (int b = 0; b < 3; b++) begin
      if (in_item.channel_mask[b+3]) begin
        q_in[b] = vals[kcnt];
        kcnt = kcnt + 3'd1;
      end
    end
  end

  // Operand views
  always_comb begin
    pv[0] = 33'(rd.qw);
    pv[1] = 33'(rd.qx);
    pv[2] = 33'(rd.qy);
    pv[3] = 33'(rd.qz);
    qv[0] = 33'(w);
    for (int i = 0; i < 3; i++) begin
      qv[i+1] = 33'(ql[i]);
      tv[i]   = 33'(tl[i]);
    end
  end

  // Multiply-accumulate operand schedule
  always_comb begin
    ma = '0;
    mb = '0;
    mac_en = 1'b0;
    msub = 1'b0;
    mclr = 1'b0;
    unique case (cmd.op)
      sfd_pkg::OP_WSQ: begin
        mac_en = 1'b1;
        mclr = (cmd.step == 4'd0);
        ma = qv[cmd.step[1:0] + 2'd1];
        mb = qv[cmd.step[1:0] + 2'd1];
      end
      sfd_pkg::OP_H: begin
        mac_en = 1'b1;
        mclr = !cmd.step[0];
        msub = cmd.step[0];
        unique case (cmd.step)
          4'd0: begin ma = pv[2]; mb = tv[2]; end
          4'd1: begin ma = pv[3]; mb = tv[1]; end
          4'd2: begin ma = pv[3]; mb = tv[0]; end
          4'd3: begin ma = pv[1]; mb = tv[2]; end
          4'd4: begin ma = pv[1]; mb = tv[1]; end
          default: begin ma = pv[2]; mb = tv[0]; end
        endcase
      end
      sfd_pkg::OP_C: begin
        mac_en = 1'b1;
        unique case (cmd.step)
          4'd0: begin ma = pv[0]; mb = h[0]; mclr = 1'b1; end
          4'd1: begin ma = pv[2]; mb = h[2]; end
          4'd2: begin ma = pv[3]; mb = h[1]; msub = 1'b1; end
          4'd3: begin ma = pv[0]; mb = h[1]; mclr = 1'b1; end
          4'd4: begin ma = pv[3]; mb = h[0]; end
          4'd5: begin ma = pv[1]; mb = h[2]; msub = 1'b1; end
          4'd6: begin ma = pv[0]; mb = h[2]; mclr = 1'b1; end
          4'd7: begin ma = pv[1]; mb = h[1]; end
          default: begin ma = pv[2]; mb = h[0]; msub = 1'b1; end
        endcase
      end
      sfd_pkg::OP_Q: begin
        mac_en = 1'b1;
        mclr = (cmd.step[1:0] == 2'd0);
        unique case (cmd.step)
          4'd0:  begin ma = pv[0]; mb = qv[0]; end
          4'd1:  begin ma = pv[1]; mb = qv[1]; msub = 1'b1; end
          4'd2:  begin ma = pv[2]; mb = qv[2]; msub = 1'b1; end
          4'd3:  begin ma = pv[3]; mb = qv[3]; msub = 1'b1; end
          4'd4:  begin ma = pv[0]; mb = qv[1]; end
          4'd5:  begin ma = pv[1]; mb = qv[0]; end
          4'd6:  begin ma = pv[2]; mb = qv[3]; end
          4'd7:  begin ma = pv[3]; mb = qv[2]; msub = 1'b1; end
          4'd8:  begin ma = pv[0]; mb = qv[2]; end
          4'd9:  begin ma = pv[1]; mb = qv[3]; msub = 1'b1; end
          4'd10: begin ma = pv[2]; mb = qv[0]; end
          4'd11: begin ma = pv[3]; mb = qv[1]; end
          4'd12: begin ma = pv[0]; mb = qv[3]; end
          4'd13: begin ma = pv[1]; mb = qv[2]; end
          4'd14: begin ma = pv[2]; mb = qv[1]; msub = 1'b1; end
          default: begin ma = pv[3]; mb = qv[0]; end
        endcase
      end
      sfd_pkg::OP_SUM: begin
        mac_en = 1'b1;
        mclr = (cmd.step == 4'd0);
        ma = 33'(signed'(s[cmd.step[1:0]][31:0]));
        mb = 33'(signed'(s[cmd.step[1:0]][31:0]));
      end
      default: begin
        mac_en = 1'b0;
      end
    endcase
  end

  assign prod     = ma * mb;
  assign acc_next = (mclr ? 66'sd0 : acc) + (msub ? -prod : prod);

  always_ff @(posedge clk) begin
    if (mac_en) acc <= acc_next;
  end

  // Translation finish: v + 4*floor(acc/2^30) + parent offset, saturated
  always_comb begin
    unique case (cmd.step)
      4'd2:    ci = 2'd0;
      4'd5:    ci = 2'd1;
      default: ci = 2'd2;
    endcase
    tsum = 40'(tl[ci]) + 40'(signed'({acc_next[65:30], 2'b00}));
    unique case (ci)
      2'd0:    tsum = tsum + 40'(rd.tx);
      2'd1:    tsum = tsum + 40'(rd.ty);
      default: tsum = tsum + 40'(rd.tz);
    endcase
    if (tsum > 40'sd2147483647) tsat = 32'sh7fffffff;
    else if (tsum < -40'sd2147483648) tsat = 32'sh80000000;
    else tsat = tsum[31:0];
  end

  // Normalizing shift: all four components step right together
  always_comb begin
    any_big = 1'b0;
    for (int i = 0; i < 4; i++) any_big = any_big | is_big(s[i], lost[i]);
  end

  // Unit commands
  assign sq_start = (cmd.op == sfd_pkg::OP_SQW_GO) || (cmd.op == sfd_pkg::OP_SQN_GO);
  assign sq_rad   = (cmd.op == sfd_pkg::OP_SQW_GO) ? (64'h1000_0000_0000_0000 - acc[63:0])
                                                    : acc[63:0];
  assign dv_start = (cmd.op == sfd_pkg::OP_DIV_GO);
  assign dv_a     = signed'(s[cmd.step[1:0]][31:0]);
  assign dv_mag   = dv_a[31] ? 32'(-dv_a) : 32'(dv_a);

  sfd_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_rad),
    .done     (sq_done),
    .root     (sq_root)
  );

  sfd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .mag   (dv_mag),
    .neg   (dv_a[31]),
    .den   (norm),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  // Working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      sfd_pkg::OP_LOAD: begin
        bone   <= in_item.bone_index;
        parent <= in_item.parent_index;
        for (int i = 0; i < 3; i++) begin
          tl[i] <= t_in[i];
          ql[i] <= clamp_q(q_in[i]);
        end
      end
      sfd_pkg::OP_SQW_GO: wzero <= (acc[63:0] >= 64'h1000_0000_0000_0000);
      sfd_pkg::OP_SQW_WAIT: if (sq_done) w <= wzero ? 32'sd0 : -signed'(sq_root);
      sfd_pkg::OP_H: if (cmd.step[0]) h[cmd.step[2:1]] <= signed'(acc_next[63:31]);
      sfd_pkg::OP_C: begin
        if (cmd.step == 4'd2 || cmd.step == 4'd5 || cmd.step == 4'd8) wt[ci] <= tsat;
      end
      sfd_pkg::OP_Q: begin
        if (cmd.step[1:0] == 2'd3) begin
          s[cmd.step[3:2]]    <= acc_next[63:0];
          lost[cmd.step[3:2]] <= 1'b0;
        end
      end
      sfd_pkg::OP_NORM: begin
        if (any_big) begin
          for (int i = 0; i < 4; i++) begin
            s[i]    <= {s[i][63], s[i][63:1]};
            lost[i] <= lost[i] | s[i][0];
          end
        end
      end
      sfd_pkg::OP_SQN_WAIT: if (sq_done) norm <= sq_root;
      sfd_pkg::OP_DIV_WAIT: if (dv_done) wq[cmd.step[1:0]] <= dv_quo;
      sfd_pkg::OP_IDENT: begin
        wq[0] <= 32'sd1073741824;
        wq[1] <= '0;
        wq[2] <= '0;
        wq[3] <= '0;
      end
      default: begin
      end
    endcase
  end

  // Result pose: a root bone passes its local pose
  always_comb begin
    if (parent[6]) begin
      res = '{tx: tl[0], ty: tl[1], tz: tl[2], qw: w, qx: ql[0], qy: ql[1], qz: ql[2]};
    end else begin
      res = '{tx: wt[0], ty: wt[1], tz: wt[2], qw: wq[0], qx: wq[1], qy: wq[2], qz: wq[3]};
    end
  end

  // Pose store: parent read, result write
  always_ff @(posedge clk) begin
    if (cmd.op == sfd_pkg::OP_FIN) pose_mem[bone] <= res;
    if (cmd.op == sfd_pkg::OP_READ) rd <= pose_mem[parent[sfd_pkg::BONE_W-1:0]];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == sfd_pkg::OP_FIN) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == sfd_pkg::OP_FIN) begin
      out_bone <= bone;
      out_pose <= res;
    end
  end

  assign stat.is_root   = parent[6];
  assign stat.sqrt_done = sq_done;
  assign stat.div_done  = dv_done;
  assign stat.norm_big  = any_big;
  assign stat.norm_zero = (sq_root == 32'd0);
  assign stat.out_free  = !out_valid || out_ready;

endmodule

>>> design/sfd_ctrl.sv
// Controller state machine: sequences accept, store read, MAC passes and unit waits.
// Depends on sfd_pkg for command and status types.
module sfd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sfd_pkg::sfd_stat_t stat,
  output sfd_pkg::sfd_cmd_t  cmd
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_READ     = 4'd1;
  localparam logic [3:0] ST_WSQ      = 4'd2;
  localparam logic [3:0] ST_SQW_GO   = 4'd3;
  localparam logic [3:0] ST_SQW_WAIT = 4'd4;
  localparam logic [3:0] ST_H        = 4'd5;
  localparam logic [3:0] ST_C        = 4'd6;
  localparam logic [3:0] ST_Q        = 4'd7;
  localparam logic [3:0] ST_NORM     = 4'd8;
  localparam logic [3:0] ST_SUM      = 4'd9;
  localparam logic [3:0] ST_SQN_GO   = 4'd10;
  localparam logic [3:0] ST_SQN_WAIT = 4'd11;
  localparam logic [3:0] ST_DIV_GO   = 4'd12;
  localparam logic [3:0] ST_DIV_WAIT = 4'd13;
  localparam logic [3:0] ST_IDENT    = 4'd14;
  localparam logic [3:0] ST_FIN      = 4'd15;

  logic [3:0] state, state_next;
  logic [3:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // Next state and command
  always_comb begin
    state_next = state;
    step_next  = step;
    cmd.op     = sfd_pkg::OP_NONE;
    cmd.step   = step;
    in_ready   = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op = sfd_pkg::OP_LOAD;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.op = sfd_pkg::OP_READ;
        step_next = '0;
        state_next = ST_WSQ;
      end
      ST_WSQ: begin
        cmd.op = sfd_pkg::OP_WSQ;
        if (step == sfd_pkg::LAST_WSQ) begin
          step_next = '0;
          state_next = ST_SQW_GO;
        end else step_next = step + 4'd1;
      end
      ST_SQW_GO: begin
        cmd.op = sfd_pkg::OP_SQW_GO;
        state_next = ST_SQW_WAIT;
      end
      ST_SQW_WAIT: begin
        cmd.op = sfd_pkg::OP_SQW_WAIT;
        if (stat.sqrt_done) begin
          step_next = '0;
          state_next = stat.is_root ? ST_FIN : ST_H;
        end
      end
      ST_H: begin
        cmd.op = sfd_pkg::OP_H;
        if (step == sfd_pkg::LAST_H) begin
          step_next = '0;
          state_next = ST_C;
        end else step_next = step + 4'd1;
      end
      ST_C: begin
        cmd.op = sfd_pkg::OP_C;
        if (step == sfd_pkg::LAST_C) begin
          step_next = '0;
          state_next = ST_Q;
        end else step_next = step + 4'd1;
      end
      ST_Q: begin
        cmd.op = sfd_pkg::OP_Q;
        if (step == sfd_pkg::LAST_Q) begin
          step_next = '0;
          state_next = ST_NORM;
        end else step_next = step + 4'd1;
      end
      ST_NORM: begin
        cmd.op = sfd_pkg::OP_NORM;
        if (!stat.norm_big) state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.op = sfd_pkg::OP_SUM;
        if (step == sfd_pkg::LAST_SUM) begin
          step_next = '0;
          state_next = ST_SQN_GO;
        end else step_next = step + 4'd1;
      end
      ST_SQN_GO: begin
        cmd.op = sfd_pkg::OP_SQN_GO;
        state_next = ST_SQN_WAIT;
      end
      ST_SQN_WAIT: begin
        cmd.op = sfd_pkg::OP_SQN_WAIT;
        if (stat.sqrt_done) begin
          step_next = '0;
          state_next = stat.norm_zero ? ST_IDENT : ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        cmd.op = sfd_pkg::OP_DIV_GO;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        cmd.op = sfd_pkg::OP_DIV_WAIT;
        if (stat.div_done) begin
          if (step == sfd_pkg::LAST_DIV) begin
            step_next = '0;
            state_next = ST_FIN;
          end else begin
            step_next = step + 4'd1;
            state_next = ST_DIV_GO;
          end
        end
      end
      ST_IDENT: begin
        cmd.op = sfd_pkg::OP_IDENT;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.op = sfd_pkg::OP_FIN;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
